// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/sxl_pkg.sv -----
// Types, constants and helpers of the S-expression lexer.
package sxl_pkg;

   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int COLUMN_BITS_DEFAULT = 16;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_STRING = 4'b0010,
      MODE_ESCAPE = 4'b0100,
      MODE_SYMBOL = 4'b1000
   } mode_type;

   localparam logic [1:0] TOK_OPEN   = 2'd0;
   localparam logic [1:0] TOK_CLOSE  = 2'd1;
   localparam logic [1:0] TOK_STRING = 2'd2;
   localparam logic [1:0] TOK_SYMBOL = 2'd3;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [7:0]  text_byte;
      logic        text_valid;
      logic        token_first;
      logic        token_last;
      logic [15:0] first_line;
      logic [15:0] first_column;
   } result_type;

   // up to two results caused by one transaction, r0 goes out first
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_type;

   function automatic result_type make_result(logic [1:0] kind, logic [7:0] text,
                                              logic valid, logic first, logic last,
                                              logic [15:0] line, logic [15:0] col);
      result_type r;
      r.token_kind   = kind;
      r.text_byte    = text;
      r.text_valid   = valid;
      r.token_first  = first;
      r.token_last   = last;
      r.first_line   = first ? line : 16'd0;
      r.first_column = first ? col : 16'd0;
      return r;
   endfunction

endpackage

// ----- rtl/sxl_step.sv -----
// Per-byte lexer decision: results, next mode and next position.
module sxl_step import sxl_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
   input  logic                   kind,
   input  logic [7:0]             source_byte,
   input  mode_type               mode,
   input  logic [LINE_BITS-1:0]   line,
   input  logic [COLUMN_BITS-1:0] column,
   output mode_type               mode_in,
   output logic [LINE_BITS-1:0]   line_in,
   output logic [COLUMN_BITS-1:0] column_in,
   output step_type               step
);

   logic [15:0] line16;
   logic [15:0] col16;
   logic        is_space;
   logic        is_print;
   logic        is_paren;
   logic [7:0]  esc_byte;

   // idle-mode handling of one byte
   logic        idle_emit;
   logic        idle_two;
   result_type  idle_r0;
   result_type  idle_r1;
   mode_type    idle_mode;
   logic        idle_col;
   logic        idle_nl;

   logic        do_col;
   logic        do_nl;
   logic        do_clear;

   assign line16   = 16'(line);
   assign col16    = 16'(column);
   assign is_space = (source_byte == CH_SPACE) || (source_byte inside {[CH_TAB:CH_CR]});
   assign is_print = source_byte inside {[8'h21:8'h7E]};
   assign is_paren = (source_byte == CH_LPAREN) || (source_byte == CH_RPAREN);

   always_comb begin
      case (source_byte)
         CH_T:    esc_byte = CH_TAB;
         CH_N:    esc_byte = CH_LF;
         CH_R:    esc_byte = CH_CR;
         default: esc_byte = source_byte;
      endcase
   end

   always_comb begin
      idle_emit = 1'b0;
      idle_two  = 1'b0;
      idle_r0   = '0;
      idle_r1   = '0;
      idle_mode = MODE_IDLE;
      idle_col  = 1'b0;
      idle_nl   = 1'b0;
      if (source_byte == CH_LPAREN) begin
         idle_emit = 1'b1;
         idle_r0   = make_result(TOK_OPEN, 8'd0, 1'b0, 1'b1, 1'b1, line16, col16);
         idle_col  = 1'b1;
      end else if (source_byte == CH_RPAREN) begin
         idle_emit = 1'b1;
         idle_r0   = make_result(TOK_CLOSE, 8'd0, 1'b0, 1'b1, 1'b1, line16, col16);
         idle_col  = 1'b1;
      end else if (source_byte == CH_QUOTE) begin
         idle_emit = 1'b1;
         idle_r0   = make_result(TOK_STRING, 8'd0, 1'b0, 1'b1, 1'b0, line16, col16);
         idle_col  = 1'b1;
         idle_mode = MODE_STRING;
      end else if (is_print) begin
         idle_emit = 1'b1;
         idle_two  = 1'b1;
         idle_r0   = make_result(TOK_SYMBOL, 8'd0, 1'b0, 1'b1, 1'b0, line16, col16);
         idle_r1   = make_result(TOK_SYMBOL, source_byte, 1'b1, 1'b0, 1'b0,
                                 line16, col16);
         idle_col  = 1'b1;
         idle_mode = MODE_SYMBOL;
      end else if (source_byte == CH_LF) begin
         idle_nl = 1'b1;
      end else if (source_byte != CH_CR) begin
         idle_col = 1'b1;
      end
   end

   always_comb begin
      step     = '0;
      mode_in  = mode;
      do_col   = 1'b0;
      do_nl    = 1'b0;
      do_clear = 1'b0;
      if (kind) begin
         // flush: close any open token, restart position
         do_clear = 1'b1;
         mode_in  = MODE_IDLE;
         if (mode == MODE_STRING || mode == MODE_ESCAPE) begin
            step.count = 2'd1;
            step.r0    = make_result(TOK_STRING, 8'd0, 1'b0, 1'b0, 1'b1, line16, col16);
         end else if (mode == MODE_SYMBOL) begin
            step.count = 2'd1;
            step.r0    = make_result(TOK_SYMBOL, 8'd0, 1'b0, 1'b0, 1'b1, line16, col16);
         end
      end else begin
         case (mode)
            MODE_STRING: begin
               if (source_byte == CH_QUOTE) begin
                  step.count = 2'd1;
                  step.r0    = make_result(TOK_STRING, 8'd0, 1'b0, 1'b0, 1'b1,
                                           line16, col16);
                  do_col     = 1'b1;
                  mode_in    = MODE_IDLE;
               end else if (source_byte == CH_BSLASH) begin
                  do_col  = 1'b1;
                  mode_in = MODE_ESCAPE;
               end else if (source_byte == CH_LF) begin
                  do_nl = 1'b1;
               end else begin
                  step.count = 2'd1;
                  step.r0    = make_result(TOK_STRING, source_byte, 1'b1, 1'b0, 1'b0,
                                           line16, col16);
                  do_col     = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_STRING;
               if (source_byte == CH_LF) begin
                  do_nl = 1'b1;
               end else begin
                  step.count = 2'd1;
                  step.r0    = make_result(TOK_STRING, esc_byte, 1'b1, 1'b0, 1'b0,
                                           line16, col16);
                  do_col     = 1'b1;
               end
            end
            MODE_SYMBOL: begin
               if (is_paren || is_space) begin
                  // end the symbol, then treat the byte as fresh idle input
                  step.count = idle_emit ? 2'd2 : 2'd1;
                  step.r0    = make_result(TOK_SYMBOL, 8'd0, 1'b0, 1'b0, 1'b1,
                                           line16, col16);
                  step.r1    = idle_r0;
                  mode_in    = idle_mode;
                  do_col     = idle_col;
                  do_nl      = idle_nl;
               end else begin
                  step.count = 2'd1;
                  step.r0    = make_result(TOK_SYMBOL, source_byte, 1'b1, 1'b0, 1'b0,
                                           line16, col16);
                  do_col     = 1'b1;
               end
            end
            default: begin
               step.count = idle_two ? 2'd2 : (idle_emit ? 2'd1 : 2'd0);
               step.r0    = idle_r0;
               step.r1    = idle_r1;
               mode_in    = idle_mode;
               do_col     = idle_col;
               do_nl      = idle_nl;
            end
         endcase
      end
   end

   always_comb begin
      line_in   = line;
      column_in = column;
      if (do_clear) begin
         line_in   = LINE_BITS'(1);
         column_in = COLUMN_BITS'(1);
      end else if (do_nl) begin
         line_in   = (line != '1) ? line + LINE_BITS'(1) : line;
         column_in = COLUMN_BITS'(1);
      end else if (do_col) begin
         column_in = (column != '1) ? column + COLUMN_BITS'(1) : column;
      end
   end

endmodule

// ----- rtl/sxl_outq.sv -----
// Result queue: takes up to two results per transaction, delivers one per cycle while rsp_ready is high.
`include "assert_macros.svh"

module sxl_outq import sxl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  step_type   step,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type head
);

   result_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] wr_ptr_next;
   logic [QCNT_BITS-1:0] cnt_ff;
   logic [QCNT_BITS-1:0] cnt_in;
   logic [QCNT_BITS-1:0] push_cnt;
   logic                 pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (cnt_ff != '0);
   assign head        = entry_ff[rd_ptr_ff];
   // leave space for the worst case of two results
   assign room        = (cnt_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign push_cnt    = push ? QCNT_BITS'(step.count) : '0;
   assign wr_ptr_next = wr_ptr_ff + QPTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + QPTR_BITS'(push_cnt);
   assign rd_ptr_in   = rd_ptr_ff + QPTR_BITS'(pop);
   assign cnt_in      = cnt_ff + push_cnt - QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push && step.count != 2'd0 && QPTR_BITS'(i) == wr_ptr_ff) begin
            entry_ff[QPTR_BITS'(i)] <= step.r0;
         end else if (push && step.count == 2'd2 && QPTR_BITS'(i) == wr_ptr_next) begin
            entry_ff[QPTR_BITS'(i)] <= step.r1;
         end
      end
   end

   `ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= QCNT_BITS'(QUEUE_DEPTH))
   `ASSERT_NOW(a_push_room, clock, reset, push, room)
   `ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1)
   `ASSERT_NOW(a_ptr_gap, clock, reset, 1'b1, wr_ptr_ff - rd_ptr_ff == QPTR_BITS'(cnt_ff))

endmodule

// ----- rtl/sexpr_lexer.sv -----
// Streaming S-expression lexer: one source byte or end-of-input flush per
// transaction, accepted at one per cycle while the queue has room. Each
// transaction yields zero, one or two result transactions (a symbol start, or
// a symbol ended by a paren, gives two); results leave through a four-entry
// queue at one per cycle while rsp_ready is high, so input is taken every
// cycle while the queue holds two or fewer results. Mode and line/column are
// registered from the accepted byte; results are written to the queue and
// appear at rsp_ in the cycle after acceptance at the earliest.
`include "assert_macros.svh"

module sexpr_lexer import sxl_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_token_kind,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_text_valid,
   output logic        rsp_token_first,
   output logic        rsp_token_last,
   output logic [15:0] rsp_first_line,
   output logic [15:0] rsp_first_column
);

   mode_type               mode_ff;
   mode_type               mode_in;
   logic [LINE_BITS-1:0]   line_ff;
   logic [LINE_BITS-1:0]   line_in;
   logic [COLUMN_BITS-1:0] column_ff;
   logic [COLUMN_BITS-1:0] column_in;
   step_type               step;
   result_type             head;
   logic                   accept;
   logic                   at_origin;
   logic [LINE_BITS+COLUMN_BITS+3:0] lex_state;

   assign accept = req_valid && req_ready;

   sxl_step #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_step (
      .kind        (req_kind),
      .source_byte (req_source_byte),
      .mode        (mode_ff),
      .line        (line_ff),
      .column      (column_ff),
      .mode_in     (mode_in),
      .line_in     (line_in),
      .column_in   (column_in),
      .step        (step)
   );

   sxl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         column_ff <= COLUMN_BITS'(1);
      end else if (accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         column_ff <= column_in;
      end
   end

   assign rsp_token_kind   = head.token_kind;
   assign rsp_text_byte    = head.text_byte;
   assign rsp_text_valid   = head.text_valid;
   assign rsp_token_first  = head.token_first;
   assign rsp_token_last   = head.token_last;
   assign rsp_first_line   = head.first_line;
   assign rsp_first_column = head.first_column;

   assign at_origin = (mode_ff == MODE_IDLE) && (line_ff == LINE_BITS'(1))
                      && (column_ff == COLUMN_BITS'(1));
   assign lex_state = {mode_ff, line_ff, column_ff};

   `ASSERT_NOW(a_pos_nonzero, clock, reset, 1'b1, line_ff != '0 && column_ff != '0)
   `ASSERT_NEXT(a_flush_clear, clock, reset, accept && req_kind, at_origin)
   `ASSERT_NEXT(a_hold_state, clock, reset, !accept, lex_state == $past(lex_state))

endmodule
